// File: rtl/core/bcdrtc_pkg.sv
// Shared types, register codes and BCD helper functions for the BCD real-time clock.
package bcdrtc_pkg;

	// Request codes carried in req_type.
	localparam logic [2:0] REQ_READ     = 3'd0;
	localparam logic [2:0] REQ_WRITE    = 3'd1;
	localparam logic [2:0] REQ_TICK     = 3'd2;
	localparam logic [2:0] REQ_PERIODIC = 3'd3;
	localparam logic [2:0] REQ_WATCHDOG = 3'd4;

	// Register indexes.
	localparam logic [3:0] RG_YEAR     = 4'd0;
	localparam logic [3:0] RG_MONTH    = 4'd1;
	localparam logic [3:0] RG_DATE     = 4'd2;
	localparam logic [3:0] RG_DOW      = 4'd3;
	localparam logic [3:0] RG_HOURS    = 4'd4;
	localparam logic [3:0] RG_MINUTES  = 4'd5;
	localparam logic [3:0] RG_SECONDS  = 4'd6;
	localparam logic [3:0] RG_CONTROL  = 4'd7;
	localparam logic [3:0] RG_WATCHDOG = 4'd8;
	localparam logic [3:0] RG_IRQEN    = 4'd9;
	localparam logic [3:0] RG_ALDATE   = 4'd10;
	localparam logic [3:0] RG_ALHOURS  = 4'd11;
	localparam logic [3:0] RG_ALMIN    = 4'd12;
	localparam logic [3:0] RG_ALSEC    = 4'd13;
	localparam logic [3:0] RG_HUND     = 4'd14;
	localparam logic [3:0] RG_FLAGS    = 4'd15;
	localparam int unsigned NUM_REGS   = 16;

	// Counter limits and wrap points.
	localparam logic [7:0] SEC_LIMIT   = 8'h59;
	localparam logic [7:0] YEAR_LIMIT  = 8'h99;
	localparam logic [7:0] OPEN_LIMIT  = 8'hff;
	localparam logic [7:0] DOW_LIMIT   = 8'h07;
	localparam logic [7:0] HOUR_WRAP   = 8'h24;
	localparam logic [7:0] MONTH_WRAP  = 8'h13;
	localparam logic [7:0] LEAP_FEB    = 8'h29;

	// Bits of each visible register that mirror the internal time.
	localparam logic [7:0] MASK_MONTH  = 8'h1f;
	localparam logic [7:0] MASK_DATE   = 8'h3f;
	localparam logic [7:0] MASK_DOW    = 8'h07;
	localparam logic [7:0] MASK_HOURS  = 8'h3f;
	localparam logic [7:0] MASK_MINSEC = 8'h7f;

	// Flag bits kept when the flag register is read.
	localparam logic [7:0] FLAG_KEEP   = 8'h07;

	// Bit positions.
	localparam int unsigned BIT_W    = 7;
	localparam int unsigned BIT_R    = 6;
	localparam int unsigned BIT_FTE  = 6;
	localparam int unsigned BIT_OSC  = 7;
	localparam int unsigned BIT_WDS  = 7;
	localparam int unsigned BIT_AIE  = 7;
	localparam int unsigned BIT_PIE  = 4;
	localparam int unsigned BIT_WDF  = 7;
	localparam int unsigned BIT_AF   = 6;
	localparam int unsigned BIT_PF   = 3;
	localparam int unsigned BIT_WILD = 7;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] reg_index;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_line;
		logic       reset_pulse;
	} rsp_t;

	// Internal time set; every field keeps all eight bits.
	typedef struct packed {
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] date;
		logic [7:0] dow;
		logic [7:0] hours;
		logic [7:0] minutes;
		logic [7:0] seconds;
		logic [7:0] hund;
	} rtc_time_t;

	typedef struct packed {
		logic       carry;
		logic [7:0] value;
	} bcd_next_t;

	// One BCD count step: out-of-range values fall back to the minimum without carry.
	function automatic bcd_next_t bcd_step(logic [7:0] x, logic [7:0] limit, logic [7:0] min);
		bcd_next_t r;
		if (x < min || x > limit || x[3:0] > 4'd9) begin
			r = '{carry: 1'b0, value: min};
		end else if (x == limit) begin
			r = '{carry: 1'b1, value: min};
		end else if (x[3:0] == 4'd9) begin
			r = '{carry: 1'b0, value: {x[7:4] + 4'd1, 4'h0}};
		end else begin
			r = '{carry: 1'b0, value: x + 8'd1};
		end
		return r;
	endfunction

	// Last date of the month, in BCD, with the month clamped to 1..12.
	function automatic logic [7:0] month_limit(logic [7:0] month, logic [7:0] year);
		logic [7:0] m;
		logic [1:0] ymod;
		logic [7:0] r;
		m = ({4'b0, month[7:4]} << 3) + ({4'b0, month[7:4]} << 1) + {4'b0, month[3:0]};
		// Decimal year mod 4: ten is two mod four.
		ymod = {month[0] & 1'b0, 1'b0} | ({year[4], 1'b0} + year[1:0]);
		if (m > 8'd12) m = 8'd12;
		if (m == 8'd0) m = 8'd1;
		case (m)
			8'd2:    r = (ymod == 2'd0) ? LEAP_FEB : 8'h28;
			8'd4:    r = 8'h30;
			8'd6:    r = 8'h30;
			8'd9:    r = 8'h30;
			8'd11:   r = 8'h30;
			default: r = 8'h31;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/bcdrtc_stream_if.sv
// Valid/ready channel carrying one payload item per transfer.
interface bcdrtc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bcd_rtc_calendar_alarm.sv
// Top level of the BCD real-time clock and calendar with alarm.
//
// Requests arrive on the req channel (read, write, one-second tick, periodic event,
// watchdog expiry) and each one produces exactly one response on the rsp channel
// carrying read data, the interrupt line and the watchdog reset pulse.
// A request is held in an input register, executed against the register set in
// the cycle it moves into the output register, and presented on rsp from there.
// Throughput is one request per cycle: the register update and calendar carry
// chain are combinational between the input and output registers.
// When the receiver stalls, the response holds in the output register and one
// more request can wait in the input register; req.ready drops only when both
// are full and rsp.ready is low.
// Reset clears both register sets to zero and empties the pipeline.
module bcd_rtc_calendar_alarm (
	input  logic              clk,
	input  logic              arst_n,
	bcdrtc_stream_if.sink     req,
	bcdrtc_stream_if.source   rsp
);

	logic             valid_s1;
	bcdrtc_pkg::req_t req_s1;
	logic             valid_s2;
	bcdrtc_pkg::rsp_t rsp_s2;
	bcdrtc_pkg::rsp_t rsp_next;
	logic             advance;

	// Stage 1 moves on whenever the output register is empty or being drained.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || !valid_s2 || rsp.ready;
	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	bcdrtc_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.exec   (advance),
		.req    (req_s1),
		.rsp    (rsp_next)
	);

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

endmodule

// File: rtl/core/bcdrtc_calendar.sv
// Combinational one-second advance of the internal time and calendar.
module bcdrtc_calendar (
	input  bcdrtc_pkg::rtc_time_t cur,
	output bcdrtc_pkg::rtc_time_t nxt
);

	bcdrtc_pkg::bcd_next_t sec_n, min_n, hour_n, dow_n, date_n, mon_n, year_n;
	logic [7:0]            date_lim;

	// Each counter's step is formed from the current value; the carries pick which apply.
	assign sec_n    = bcdrtc_pkg::bcd_step(cur.seconds, bcdrtc_pkg::SEC_LIMIT, 8'h00);
	assign min_n    = bcdrtc_pkg::bcd_step(cur.minutes, bcdrtc_pkg::SEC_LIMIT, 8'h00);
	assign hour_n   = bcdrtc_pkg::bcd_step(cur.hours, bcdrtc_pkg::OPEN_LIMIT, 8'h00);
	assign dow_n    = bcdrtc_pkg::bcd_step(cur.dow, bcdrtc_pkg::DOW_LIMIT, 8'h01);
	assign date_lim = bcdrtc_pkg::month_limit(cur.month, cur.year);
	assign date_n   = bcdrtc_pkg::bcd_step(cur.date, date_lim, 8'h01);
	assign mon_n    = bcdrtc_pkg::bcd_step(cur.month, bcdrtc_pkg::OPEN_LIMIT, 8'h01);
	assign year_n   = bcdrtc_pkg::bcd_step(cur.year, bcdrtc_pkg::YEAR_LIMIT, 8'h00);

	// Ripple the carries from seconds up to the year.
	always_comb begin
		nxt         = cur;
		nxt.hund    = 8'h00;
		nxt.seconds = sec_n.value;
		if (sec_n.carry) begin
			nxt.minutes = min_n.value;
			if (min_n.carry) begin
				nxt.hours = hour_n.value;
				if (hour_n.value == bcdrtc_pkg::HOUR_WRAP) begin
					nxt.hours = 8'h00;
					nxt.dow   = dow_n.value;
					nxt.date  = date_n.value;
					if (date_n.carry) begin
						if (mon_n.value == bcdrtc_pkg::MONTH_WRAP) begin
							nxt.month = 8'h01;
							nxt.year  = year_n.value;
						end else begin
							nxt.month = mon_n.value;
						end
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/bcdrtc_regfile.sv
// Visible and internal register sets with the per-request update logic.
module bcdrtc_regfile (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  exec,
	input  bcdrtc_pkg::req_t      req,
	output bcdrtc_pkg::rsp_t      rsp
);

	logic [7:0]            vis_q [bcdrtc_pkg::NUM_REGS];
	logic [7:0]            vis_d [bcdrtc_pkg::NUM_REGS];
	bcdrtc_pkg::rtc_time_t tm_q, tm_d;
	bcdrtc_pkg::rtc_time_t tick_time;
	bcdrtc_pkg::rtc_time_t load_time;
	logic [7:0]            rd;
	logic                  pulse;
	logic                  run;
	logic                  copy;
	logic                  alarm;

	// Alarm field match; bit 7 of the alarm register is a wildcard once AF is set.
	function automatic logic alarm_hit(logic [7:0] now, logic [7:0] al, logic [7:0] mask,
			logic af);
		return (al[bcdrtc_pkg::BIT_WILD] & af) || ((now & mask) == (al & mask));
	endfunction

	bcdrtc_calendar u_calendar (
		.cur (tm_q),
		.nxt (tick_time)
	);

	// Internal time as loaded from the visible registers when W is cleared.
	always_comb begin
		load_time.year    = vis_q[bcdrtc_pkg::RG_YEAR];
		load_time.month   = vis_q[bcdrtc_pkg::RG_MONTH] & bcdrtc_pkg::MASK_MONTH;
		load_time.date    = vis_q[bcdrtc_pkg::RG_DATE] & bcdrtc_pkg::MASK_DATE;
		load_time.dow     = vis_q[bcdrtc_pkg::RG_DOW] & bcdrtc_pkg::MASK_DOW;
		load_time.hours   = vis_q[bcdrtc_pkg::RG_HOURS] & bcdrtc_pkg::MASK_HOURS;
		load_time.minutes = vis_q[bcdrtc_pkg::RG_MINUTES] & bcdrtc_pkg::MASK_MINSEC;
		load_time.seconds = vis_q[bcdrtc_pkg::RG_SECONDS] & bcdrtc_pkg::MASK_MINSEC;
		load_time.hund    = vis_q[bcdrtc_pkg::RG_HUND];
	end

	// The clock runs unless the frequency test or the oscillator stop bit is set.
	assign run  = !(vis_q[bcdrtc_pkg::RG_DOW][bcdrtc_pkg::BIT_FTE] ||
			vis_q[bcdrtc_pkg::RG_SECONDS][bcdrtc_pkg::BIT_OSC]);
	assign copy = !(vis_q[bcdrtc_pkg::RG_CONTROL][bcdrtc_pkg::BIT_W] ||
			vis_q[bcdrtc_pkg::RG_CONTROL][bcdrtc_pkg::BIT_R]);
	assign alarm =
		alarm_hit(tick_time.date, vis_q[bcdrtc_pkg::RG_ALDATE], bcdrtc_pkg::MASK_DATE,
			vis_q[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_AF]) &&
		alarm_hit(tick_time.hours, vis_q[bcdrtc_pkg::RG_ALHOURS], bcdrtc_pkg::MASK_HOURS,
			vis_q[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_AF]) &&
		alarm_hit(tick_time.minutes, vis_q[bcdrtc_pkg::RG_ALMIN], bcdrtc_pkg::MASK_MINSEC,
			vis_q[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_AF]) &&
		alarm_hit(tick_time.seconds, vis_q[bcdrtc_pkg::RG_ALSEC], bcdrtc_pkg::MASK_MINSEC,
			vis_q[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_AF]);

	// Next state and result for the request being executed.
	always_comb begin
		vis_d = vis_q;
		tm_d  = tm_q;
		rd    = 8'h00;
		pulse = 1'b0;
		if (exec) begin
			case (req.req_type)
				bcdrtc_pkg::REQ_READ: begin
					rd = vis_q[req.reg_index];
					if (req.reg_index == bcdrtc_pkg::RG_FLAGS) begin
						vis_d[bcdrtc_pkg::RG_FLAGS] =
							vis_q[bcdrtc_pkg::RG_FLAGS] & bcdrtc_pkg::FLAG_KEEP;
					end
				end
				bcdrtc_pkg::REQ_WRITE: begin
					if (req.reg_index != bcdrtc_pkg::RG_FLAGS) begin
						if (req.reg_index == bcdrtc_pkg::RG_CONTROL &&
								vis_q[bcdrtc_pkg::RG_CONTROL][bcdrtc_pkg::BIT_W] &&
								!req.write_data[bcdrtc_pkg::BIT_W]) begin
							tm_d = load_time;
						end
						vis_d[req.reg_index] = req.write_data;
					end
				end
				bcdrtc_pkg::REQ_TICK: begin
					if (run) begin
						tm_d = tick_time;
						if (copy) begin
							vis_d[bcdrtc_pkg::RG_YEAR] = tick_time.year;
							vis_d[bcdrtc_pkg::RG_MONTH] =
								(vis_q[bcdrtc_pkg::RG_MONTH] & ~bcdrtc_pkg::MASK_MONTH) |
								(tick_time.month & bcdrtc_pkg::MASK_MONTH);
							vis_d[bcdrtc_pkg::RG_DATE] =
								(vis_q[bcdrtc_pkg::RG_DATE] & ~bcdrtc_pkg::MASK_DATE) |
								(tick_time.date & bcdrtc_pkg::MASK_DATE);
							vis_d[bcdrtc_pkg::RG_DOW] =
								(vis_q[bcdrtc_pkg::RG_DOW] & ~bcdrtc_pkg::MASK_DOW) |
								(tick_time.dow & bcdrtc_pkg::MASK_DOW);
							vis_d[bcdrtc_pkg::RG_HOURS] =
								(vis_q[bcdrtc_pkg::RG_HOURS] & ~bcdrtc_pkg::MASK_HOURS) |
								(tick_time.hours & bcdrtc_pkg::MASK_HOURS);
							vis_d[bcdrtc_pkg::RG_MINUTES] =
								(vis_q[bcdrtc_pkg::RG_MINUTES] & ~bcdrtc_pkg::MASK_MINSEC) |
								(tick_time.minutes & bcdrtc_pkg::MASK_MINSEC);
							vis_d[bcdrtc_pkg::RG_SECONDS] =
								(vis_q[bcdrtc_pkg::RG_SECONDS] & ~bcdrtc_pkg::MASK_MINSEC) |
								(tick_time.seconds & bcdrtc_pkg::MASK_MINSEC);
							vis_d[bcdrtc_pkg::RG_HUND] = tick_time.hund;
						end
						if (alarm) begin
							vis_d[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_AF] = 1'b1;
						end
					end
				end
				bcdrtc_pkg::REQ_PERIODIC: begin
					if (vis_q[bcdrtc_pkg::RG_DOW][bcdrtc_pkg::BIT_FTE]) begin
						vis_d[bcdrtc_pkg::RG_SECONDS][0] = ~vis_q[bcdrtc_pkg::RG_SECONDS][0];
					end else begin
						vis_d[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_PF] = 1'b1;
					end
				end
				bcdrtc_pkg::REQ_WATCHDOG: begin
					vis_d[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_WDF] = 1'b1;
					if (vis_q[bcdrtc_pkg::RG_WATCHDOG][bcdrtc_pkg::BIT_WDS]) begin
						pulse = 1'b1;
						vis_d[bcdrtc_pkg::RG_WATCHDOG] = 8'h00;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Interrupt line follows the registers as they stand after the request.
	always_comb begin
		rsp.read_data   = rd;
		rsp.reset_pulse = pulse;
		rsp.irq_line    =
			(vis_d[bcdrtc_pkg::RG_IRQEN][bcdrtc_pkg::BIT_AIE] &&
			 vis_d[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_AF]) ||
			(vis_d[bcdrtc_pkg::RG_IRQEN][bcdrtc_pkg::BIT_PIE] &&
			 vis_d[bcdrtc_pkg::RG_FLAGS][bcdrtc_pkg::BIT_PF]);
	end

	// Register state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bcdrtc_pkg::NUM_REGS; i++) begin
				vis_q[i] <= 8'h00;
			end
			tm_q <= '0;
		end else begin
			vis_q <= vis_d;
			tm_q  <= tm_d;
		end
	end

endmodule

// File: rtl/core/bcdrtc_checker.sv
// Port-level assertions for the BCD real-time clock, bound to the top level.
module bcdrtc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input bcdrtc_pkg::rsp_t rsp_data
);

	// A stalled response stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// With the output register empty the block always takes a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with empty output register");

	// A request transfer into an empty output side shows a response once it has passed the input and output registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
		else $error("response missing after request transfer");

	// A watchdog reset pulse never comes with read data.
	a_pulse_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.reset_pulse |-> rsp_data.read_data == 8'h00)
		else $error("reset pulse with nonzero read data");

endmodule

bind bcd_rtc_calendar_alarm bcdrtc_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// File: test/bcdrtc_check_pkg.sv
// Scoreboard class that predicts and checks the responses of the BCD real-time clock.
`timescale 1ns / 1ps
package bcdrtc_check_pkg;
	import bcdrtc_pkg::*;

	class rtc_scoreboard;
		logic [7:0]  vis [NUM_REGS];
		logic [7:0]  itm [NUM_REGS];
		rsp_t        expected_q [$];
		int unsigned failures;

		function new();
			for (int i = 0; i < NUM_REGS; i++) begin
				vis[i] = 8'h00;
				itm[i] = 8'h00;
			end
			failures = 0;
		endfunction

		// Bits of each visible register that follow the internal time.
		function logic [7:0] mirror_bits(int unsigned idx);
			case (idx)
				RG_YEAR, RG_HUND: return 8'hff;
				RG_MONTH:         return MASK_MONTH;
				RG_DATE:          return MASK_DATE;
				RG_DOW:           return MASK_DOW;
				RG_HOURS:         return MASK_HOURS;
				RG_MINUTES:       return MASK_MINSEC;
				RG_SECONDS:       return MASK_MINSEC;
				default:          return 8'h00;
			endcase
		endfunction

		// One BCD count, returned as {carry, next value}; bad values restart at the base.
		function logic [8:0] bcd_count(logic [7:0] x, logic [7:0] top, logic [7:0] base);
			if (x < base || x > top || x[3:0] > 4'd9)
				return {1'b0, base};
			if (x == top)
				return {1'b1, base};
			if (x[3:0] == 4'd9)
				return {1'b0, x[7:4] + 4'd1, 4'h0};
			return {1'b0, x + 8'd1};
		endfunction

		function int unsigned bcd_decimal(logic [7:0] x);
			return x[7:4] * 10 + x[3:0];
		endfunction

		// Day carry: day of week, date against the month length, month and year.
		function void advance_day();
			int unsigned m;
			logic [7:0]  month_end;
			logic [8:0]  nx;
			m = bcd_decimal(itm[RG_MONTH]);
			if (m > 12)
				m = 12;
			if (m == 0)
				m = 1;
			case (m)
				2:           month_end = (bcd_decimal(itm[RG_YEAR]) % 4 == 0) ? 8'h29 : 8'h28;
				4, 6, 9, 11: month_end = 8'h30;
				default:     month_end = 8'h31;
			endcase
			nx = bcd_count(itm[RG_DOW], DOW_LIMIT, 8'h01);
			itm[RG_DOW] = nx[7:0];
			nx = bcd_count(itm[RG_DATE], month_end, 8'h01);
			itm[RG_DATE] = nx[7:0];
			if (nx[8]) begin
				nx = bcd_count(itm[RG_MONTH], 8'hff, 8'h01);
				itm[RG_MONTH] = nx[7:0];
				if (itm[RG_MONTH] == MONTH_WRAP) begin
					itm[RG_MONTH] = 8'h01;
					nx = bcd_count(itm[RG_YEAR], YEAR_LIMIT, 8'h00);
					itm[RG_YEAR] = nx[7:0];
				end
			end
		endfunction

		// An alarm field matches when it is a wildcard or equals the internal time.
		function logic alarm_field_hit(int unsigned now_idx, int unsigned al_idx,
				logic [7:0] m);
			return (vis[al_idx][BIT_WILD] && vis[RG_FLAGS][BIT_AF]) ||
				((itm[now_idx] & m) == (vis[al_idx] & m));
		endfunction

		// One-second tick unless stopped: count, copy to the visible set unless W or R is set, then compare the alarm.
		function void second_tick();
			logic [8:0] nx;
			logic [7:0] m;
			if (vis[RG_DOW][BIT_FTE] || vis[RG_SECONDS][BIT_OSC])
				return;
			itm[RG_HUND] = 8'h00;
			nx = bcd_count(itm[RG_SECONDS], SEC_LIMIT, 8'h00);
			itm[RG_SECONDS] = nx[7:0];
			if (nx[8]) begin
				nx = bcd_count(itm[RG_MINUTES], SEC_LIMIT, 8'h00);
				itm[RG_MINUTES] = nx[7:0];
				if (nx[8]) begin
					nx = bcd_count(itm[RG_HOURS], 8'hff, 8'h00);
					itm[RG_HOURS] = nx[7:0];
					if (itm[RG_HOURS] == HOUR_WRAP) begin
						itm[RG_HOURS] = 8'h00;
						advance_day();
					end
				end
			end
			if (!vis[RG_CONTROL][BIT_W] && !vis[RG_CONTROL][BIT_R]) begin
				for (int i = 0; i < NUM_REGS; i++) begin
					m = mirror_bits(i);
					vis[i] = (vis[i] & ~m) | (itm[i] & m);
				end
			end
			if (alarm_field_hit(RG_DATE, RG_ALDATE, MASK_DATE) &&
					alarm_field_hit(RG_HOURS, RG_ALHOURS, MASK_HOURS) &&
					alarm_field_hit(RG_MINUTES, RG_ALMIN, MASK_MINSEC) &&
					alarm_field_hit(RG_SECONDS, RG_ALSEC, MASK_MINSEC))
				vis[RG_FLAGS][BIT_AF] = 1'b1;
		endfunction

		// Apply one accepted request and queue the response it must produce.
		function void note_request(req_t r);
			rsp_t e;
			e = '0;
			case (r.req_type)
				REQ_READ: begin
					e.read_data = vis[r.reg_index];
					if (r.reg_index == RG_FLAGS)
						vis[RG_FLAGS] = vis[RG_FLAGS] & FLAG_KEEP;
				end
				REQ_WRITE: begin
					if (r.reg_index != RG_FLAGS) begin
						// Clearing W loads the internal time from the visible set.
						if (r.reg_index == RG_CONTROL && vis[RG_CONTROL][BIT_W] &&
								!r.write_data[BIT_W]) begin
							for (int i = 0; i < NUM_REGS; i++)
								itm[i] = vis[i] & mirror_bits(i);
						end
						vis[r.reg_index] = r.write_data;
					end
				end
				REQ_TICK: begin
					second_tick();
				end
				REQ_PERIODIC: begin
					if (vis[RG_DOW][BIT_FTE])
						vis[RG_SECONDS] = vis[RG_SECONDS] ^ 8'h01;
					else
						vis[RG_FLAGS][BIT_PF] = 1'b1;
				end
				REQ_WATCHDOG: begin
					vis[RG_FLAGS][BIT_WDF] = 1'b1;
					if (vis[RG_WATCHDOG][BIT_WDS]) begin
						e.reset_pulse = 1'b1;
						vis[RG_WATCHDOG] = 8'h00;
					end
				end
				default: begin
				end
			endcase
			e.irq_line = (vis[RG_IRQEN][BIT_AIE] && vis[RG_FLAGS][BIT_AF]) ||
				(vis[RG_IRQEN][BIT_PIE] && vis[RG_FLAGS][BIT_PF]);
			expected_q.push_back(e);
		endfunction

		// Compare one response transfer with the oldest expectation.
		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %h", $time, got);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (got.read_data !== want.read_data) begin
				$display("%0t: read_data expected %h actual %h", $time,
					want.read_data, got.read_data);
				failures++;
			end
			if (got.irq_line !== want.irq_line) begin
				$display("%0t: irq_line expected %b actual %b", $time,
					want.irq_line, got.irq_line);
				failures++;
			end
			if (got.reset_pulse !== want.reset_pulse) begin
				$display("%0t: reset_pulse expected %b actual %b", $time,
					want.reset_pulse, got.reset_pulse);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

// File: test/bcd_rtc_calendar_alarm_test.sv
// Testbench top: drives requests into the BCD real-time clock and checks every response.
`timescale 1ns / 1ps
module bcd_rtc_calendar_alarm_test;
	import bcdrtc_pkg::*;
	import bcdrtc_check_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned RANDOM_ITEMS = 1000;
	localparam logic [2:0]  REQ_UNUSED   = 3'd7;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          calm;
	int unsigned   sent_count;
	int unsigned   quiet_cycles = 0;
	rtc_scoreboard sb;

	bcdrtc_stream_if #(.payload_t(req_t)) req_ch ();
	bcdrtc_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	bcd_rtc_calendar_alarm u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver stalls in about 30 percent of cycles unless calm is set.
	always @(posedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(99) >= 30);
	end

	// Every response transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.data);
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request after a random gap and wait for its transfer.
	task automatic send_req(req_t r);
		while (!calm && $urandom_range(99) < 30) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		sb.note_request(r);
		sent_count++;
	endtask

	task automatic put_reg(logic [3:0] idx, logic [7:0] value);
		req_t r;
		r.req_type   = REQ_WRITE;
		r.reg_index  = idx;
		r.write_data = value;
		send_req(r);
	endtask

	task automatic get_reg(logic [3:0] idx);
		req_t r;
		r.req_type   = REQ_READ;
		r.reg_index  = idx;
		r.write_data = 8'($urandom);
		send_req(r);
	endtask

	// Requests that ignore the index and data carry random ones.
	task automatic send_event(logic [2:0] kind);
		req_t r;
		r.req_type   = kind;
		r.reg_index  = 4'($urandom);
		r.write_data = 8'($urandom);
		send_req(r);
	endtask

	task automatic tick_burst(int unsigned n);
		repeat (n) send_event(REQ_TICK);
	endtask

	function automatic logic [7:0] to_bcd(int unsigned d);
		logic [3:0] tens;
		logic [3:0] ones;
		tens = 4'(d / 10);
		ones = 4'(d % 10);
		return {tens, ones};
	endfunction

	// Alarm field: usually the coming time value, with a random wildcard bit.
	function automatic logic [7:0] pick_alarm(logic [7:0] v);
		logic [6:0] low;
		low = ($urandom_range(3) != 0) ? v[6:0] : 7'($urandom);
		return {1'($urandom), low};
	endfunction

	// Set the time with W, mostly near rollover points, then let it run.
	task automatic set_clock();
		logic [7:0] v;
		put_reg(RG_CONTROL, 8'h80 | 8'($urandom_range(63)));
		case ($urandom_range(4))
			0:       v = 8'h99;
			1:       v = 8'h00;
			2:       v = to_bcd(4 * $urandom_range(24));
			3:       v = to_bcd($urandom_range(99));
			default: v = 8'($urandom);
		endcase
		put_reg(RG_YEAR, v);
		case ($urandom_range(4))
			0:       v = 8'h12;
			1:       v = 8'h02;
			2:       v = 8'h00;
			3:       v = to_bcd($urandom_range(1, 12));
			default: v = 8'($urandom);
		endcase
		put_reg(RG_MONTH, v);
		case ($urandom_range(5))
			0:       v = 8'h28;
			1:       v = 8'h29;
			2:       v = 8'h30;
			3:       v = 8'h31;
			4:       v = to_bcd($urandom_range(1, 31));
			default: v = 8'($urandom);
		endcase
		put_reg(RG_DATE, v);
		// Keep the clock running in most sequences.
		v = 8'($urandom) & 8'hbf;
		if ($urandom_range(15) == 0)
			v[BIT_FTE] = 1'b1;
		put_reg(RG_DOW, v);
		case ($urandom_range(2))
			0:       v = 8'h23;
			1:       v = to_bcd($urandom_range(23));
			default: v = 8'($urandom);
		endcase
		put_reg(RG_HOURS, v);
		case ($urandom_range(3))
			0, 1:    v = 8'h59;
			2:       v = to_bcd($urandom_range(59));
			default: v = 8'($urandom);
		endcase
		put_reg(RG_MINUTES, v);
		case ($urandom_range(3))
			0:       v = 8'h58;
			1:       v = 8'h59;
			2:       v = to_bcd($urandom_range(59));
			default: v = 8'($urandom) & 8'h7f;
		endcase
		if ($urandom_range(15) == 0)
			v[BIT_OSC] = 1'b1;
		put_reg(RG_SECONDS, v);
		put_reg(RG_HUND, 8'($urandom));
		v = 8'($urandom_range(63));
		if ($urandom_range(7) == 0)
			v[BIT_R] = 1'b1;
		put_reg(RG_CONTROL, v);
		tick_burst($urandom_range(1, 6));
	endtask

	// Aim the alarm at the next second and enable interrupts at random.
	task automatic set_alarm();
		logic [8:0] nx;
		nx = sb.bcd_count(sb.itm[RG_SECONDS], SEC_LIMIT, 8'h00);
		put_reg(RG_ALDATE, pick_alarm(sb.itm[RG_DATE]));
		put_reg(RG_ALHOURS, pick_alarm(sb.itm[RG_HOURS]));
		put_reg(RG_ALMIN, pick_alarm(sb.itm[RG_MINUTES]));
		put_reg(RG_ALSEC, pick_alarm(nx[7:0]));
		put_reg(RG_IRQEN, 8'($urandom));
		tick_burst($urandom_range(1, 4));
	endtask

	initial begin
		int unsigned base;
		int unsigned roll;
		sb = new();
		sent_count    = 0;
		arst_n       <= 1'b0;
		calm         <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rollover of every counter at once, from the last second of year 99.
		put_reg(RG_CONTROL, 8'h80);
		put_reg(RG_YEAR, 8'h99);
		put_reg(RG_MONTH, 8'h12);
		put_reg(RG_DATE, 8'h31);
		put_reg(RG_HOURS, 8'h23);
		put_reg(RG_MINUTES, 8'h59);
		put_reg(RG_SECONDS, 8'h59);
		put_reg(RG_DOW, 8'h07);
		put_reg(RG_CONTROL, 8'h00);
		// Alarm at the new year with both interrupts enabled.
		put_reg(RG_IRQEN, 8'h90);
		put_reg(RG_ALDATE, 8'h01);
		put_reg(RG_ALHOURS, 8'h00);
		put_reg(RG_ALMIN, 8'h00);
		put_reg(RG_ALSEC, 8'h00);
		send_event(REQ_TICK);
		get_reg(RG_FLAGS);
		send_event(REQ_PERIODIC);
		// Watchdog expiry with steering to the reset pulse.
		put_reg(RG_WATCHDOG, 8'h80);
		send_event(REQ_WATCHDOG);
		put_reg(RG_FLAGS, 8'hff);
		get_reg(RG_FLAGS);
		// Test mode stops the clock and turns periodic events into a seconds toggle.
		put_reg(RG_DOW, 8'h40);
		send_event(REQ_TICK);
		send_event(REQ_PERIODIC);
		put_reg(RG_DOW, 8'h01);
		// Oscillator stop bit holds the time.
		put_reg(RG_SECONDS, 8'h80);
		send_event(REQ_TICK);
		send_event(REQ_UNUSED);

		// Random part, mostly well-formed time and alarm sequences.
		base = sent_count;
		while (sent_count - base < RANDOM_ITEMS) begin
			calm <= (sent_count - base >= 300) && (sent_count - base < 450);
			roll = $urandom_range(99);
			if (roll < 25) begin
				set_clock();
			end else if (roll < 45) begin
				tick_burst($urandom_range(1, 20));
			end else if (roll < 55) begin
				set_alarm();
			end else if (roll < 70) begin
				get_reg(($urandom_range(2) == 0) ? RG_FLAGS : 4'($urandom));
			end else if (roll < 77) begin
				send_event(REQ_PERIODIC);
			end else if (roll < 84) begin
				if ($urandom_range(1) == 0)
					put_reg(RG_WATCHDOG, 8'($urandom));
				send_event(REQ_WATCHDOG);
			end else if (roll < 90) begin
				put_reg(4'($urandom), 8'($urandom));
			end else if (roll < 96) begin
				put_reg(RG_CONTROL, {1'b0, 1'($urandom_range(3) == 0), 6'($urandom)});
			end else begin
				send_event(3'($urandom));
			end
		end
		req_ch.valid <= 1'b0;
		calm         <= 1'b0;

		// Drain the remaining responses, then allow for the pipeline depth.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
